FILE: src/cmf_pkg.sv
package cmf_pkg;

    localparam int REG_FACTORS      = 4;
    localparam int FACTOR_W         = 16;
    localparam int COUNT_W          = 3;
    localparam int LIMIT_W          = 32;
    localparam int RESULT_W         = 32;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int REG_IDX_W        = 2;

    localparam int DEF_MAX_FACTORS  = 4;
    localparam int DEF_LIMIT_BITS   = 32;

    localparam logic [COUNT_W-1:0]  RST_FACTOR_COUNT = 3'd4;
    localparam logic [FACTOR_W-1:0] RST_FACTOR_A     = 16'd2;
    localparam logic [FACTOR_W-1:0] RST_FACTOR_B     = 16'd3;
    localparam logic [FACTOR_W-1:0] RST_FACTOR_C     = 16'd5;
    localparam logic [FACTOR_W-1:0] RST_FACTOR_D     = 16'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_A     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_B     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_C     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_D     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_DIV,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

FILE: src/cmf_limit_if.sv
interface cmf_limit_if;
    logic                         valid;
    logic                         ready;
    logic [cmf_pkg::LIMIT_W-1:0]  upper_limit;

    modport source (output valid, output upper_limit, input ready);
    modport sink   (input valid, input upper_limit, output ready);
endinterface

FILE: src/cmf_count_if.sv
interface cmf_count_if;
    logic                          valid;
    logic                          ready;
    logic [cmf_pkg::RESULT_W-1:0]  multiple_count;

    modport source (output valid, output multiple_count, input ready);
    modport sink   (input valid, input multiple_count, output ready);
endinterface

FILE: src/cmf_cfg_if.sv
interface cmf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cmf_pkg::CFG_INDEX_W-1:0]  index;
    logic [cmf_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/count_multiples_of_any_factor.sv
// A query walks every nonzero subset of the n active factors and forms its product;
// if that is nonzero and not above the limit, the LB-bit limit is divided by it.
// The bit-serial restoring divider gives one quotient bit per cycle; LB = min(LIMIT_BITS, 32).
// One word in flight: a new word is accepted only in idle, once the last result is issued;
// the next word is accepted while a result waits.
// Reset (synchronous, active low) restores the factor registers and returns to idle.
module count_multiples_of_any_factor #(
    parameter int MAX_FACTORS = cmf_pkg::DEF_MAX_FACTORS,
    parameter int LIMIT_BITS  = cmf_pkg::DEF_LIMIT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cmf_cfg_if.sink      i_cfg,
    cmf_limit_if.sink    i_limit,
    cmf_count_if.source  o_count
);

    localparam int NF = (MAX_FACTORS < cmf_pkg::REG_FACTORS) ? MAX_FACTORS
                                                              : cmf_pkg::REG_FACTORS;
    localparam int LB = (LIMIT_BITS < cmf_pkg::LIMIT_W) ? LIMIT_BITS : cmf_pkg::LIMIT_W;
    localparam int NW = $clog2(NF + 1);
    localparam int KW = (NF > 1) ? $clog2(NF) : 1;
    localparam int PW = LB + cmf_pkg::FACTOR_W;
    localparam int AW = LB + 5;
    localparam int CW = $clog2(LB);

    logic [cmf_pkg::FACTOR_W-1:0] r_factor [cmf_pkg::REG_FACTORS];
    logic [cmf_pkg::COUNT_W-1:0]  r_factor_count;

    cmf_pkg::t_state r_state, n_state;

    logic [LB-1:0]        r_m, n_m;
    logic [NF-1:0]        r_subset, n_subset;
    logic [KW-1:0]        r_k, n_k;
    logic [NW-1:0]        r_n, n_n;
    logic [LB-1:0]        r_prod, n_prod;
    logic                 r_odd, n_odd;
    logic [LB-1:0]        r_rem, n_rem;
    logic [LB-1:0]        r_quo, n_quo;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic signed [AW-1:0] r_acc, n_acc;
    logic                 r_out_valid, n_out_valid;
    logic [cmf_pkg::RESULT_W-1:0] r_out_count, n_out_count;

    logic                          accept;
    logic [NW-1:0]                 active_n;
    logic [cmf_pkg::FACTOR_W-1:0]  factor_sel;
    logic [PW-1:0]                 prod_full;
    logic                          prod_dead;
    logic                          bit_set;
    logic                          last_k;
    logic [NF-1:0]                 subset_last;
    logic [LB:0]                   trial;
    logic                          trial_ge;
    logic [LB-1:0]                 quo_next;
    logic [LB:0]                   trial_diff;
    logic [LB-1:0]                 clamped;
    logic                          out_free;

    assign i_cfg.ready            = 1'b1;
    assign i_limit.ready          = (r_state == cmf_pkg::S_IDLE);
    assign o_count.valid          = r_out_valid;
    assign o_count.multiple_count = r_out_count;

    assign accept   = i_limit.valid && i_limit.ready;
    assign out_free = !r_out_valid || o_count.ready;

    assign active_n = (r_factor_count > cmf_pkg::COUNT_W'(NF)) ? NW'(NF)
                                                                : NW'(r_factor_count);

    assign factor_sel  = r_factor[cmf_pkg::REG_IDX_W'(r_k)];
    assign prod_full   = PW'(r_prod) * PW'(factor_sel);
    assign prod_dead   = (prod_full == '0) || (prod_full > PW'(r_m));
    assign bit_set     = r_subset[r_k];
    assign last_k      = ((NW'(r_k) + NW'(1)) == r_n);
    assign subset_last = ~({NF{1'b1}} << r_n);

    assign trial      = {r_rem, r_quo[LB-1]};
    assign trial_ge   = (trial >= {1'b0, r_prod});
    assign trial_diff = trial - {1'b0, r_prod};
    assign quo_next   = {r_quo[LB-2:0], trial_ge};

    always_comb begin
        if (r_acc[AW-1]) begin
            clamped = '0;
        end else if (r_acc > AW'(r_m)) begin
            clamped = r_m;
        end else begin
            clamped = r_acc[LB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor_count <= cmf_pkg::RST_FACTOR_COUNT;
            r_factor[0]    <= cmf_pkg::RST_FACTOR_A;
            r_factor[1]    <= cmf_pkg::RST_FACTOR_B;
            r_factor[2]    <= cmf_pkg::RST_FACTOR_C;
            r_factor[3]    <= cmf_pkg::RST_FACTOR_D;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                cmf_pkg::CFG_FACTOR_COUNT: begin
                    r_factor_count <= i_cfg.data[cmf_pkg::COUNT_W-1:0];
                end
                cmf_pkg::CFG_FACTOR_A: r_factor[0] <= i_cfg.data;
                cmf_pkg::CFG_FACTOR_B: r_factor[1] <= i_cfg.data;
                cmf_pkg::CFG_FACTOR_C: r_factor[2] <= i_cfg.data;
                cmf_pkg::CFG_FACTOR_D: r_factor[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cmf_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (active_n == '0) ? cmf_pkg::S_DONE : cmf_pkg::S_PROD;
                end
            end
            cmf_pkg::S_PROD: begin
                if (bit_set && prod_dead) begin
                    n_state = cmf_pkg::S_NEXT;
                end else if (last_k) begin
                    n_state = cmf_pkg::S_DIV;
                end
            end
            cmf_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = cmf_pkg::S_NEXT;
                end
            end
            cmf_pkg::S_NEXT: begin
                n_state = (r_subset == subset_last) ? cmf_pkg::S_DONE : cmf_pkg::S_PROD;
            end
            cmf_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = cmf_pkg::S_IDLE;
                end
            end
            default: n_state = cmf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_m         = r_m;
        n_subset    = r_subset;
        n_k         = r_k;
        n_n         = r_n;
        n_prod      = r_prod;
        n_odd       = r_odd;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        if (r_out_valid && o_count.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            cmf_pkg::S_IDLE: begin
                if (accept) begin
                    n_m      = i_limit.upper_limit[LB-1:0];
                    n_n      = active_n;
                    n_subset = NF'(1);
                    n_k      = '0;
                    n_prod   = LB'(1);
                    n_odd    = 1'b0;
                    n_acc    = '0;
                end
            end
            cmf_pkg::S_PROD: begin
                if (bit_set && !prod_dead) begin
                    n_prod = prod_full[LB-1:0];
                    n_odd  = !r_odd;
                end
                n_k   = r_k + KW'(1);
                n_rem = '0;
                n_quo = r_m;
                n_cnt = CW'(LB - 1);
            end
            cmf_pkg::S_DIV: begin
                n_rem = trial_ge ? trial_diff[LB-1:0] : trial[LB-1:0];
                n_quo = quo_next;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_acc = r_odd ? (r_acc + AW'(quo_next)) : (r_acc - AW'(quo_next));
                end
            end
            cmf_pkg::S_NEXT: begin
                n_subset = r_subset + NF'(1);
                n_k      = '0;
                n_prod   = LB'(1);
                n_odd    = 1'b0;
            end
            cmf_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = cmf_pkg::RESULT_W'(clamped);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m         <= n_m;
        r_subset    <= n_subset;
        r_k         <= n_k;
        r_n         <= n_n;
        r_prod      <= n_prod;
        r_odd       <= n_odd;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_acc       <= n_acc;
        r_out_count <= n_out_count;
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmf_pkg::S_DIV) |-> (r_prod != '0))
        else $error("Divider started with a zero product.");

    a_div_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmf_pkg::S_DIV) |-> (r_prod <= r_m))
        else $error("Divider started with a product above the limit.");

    a_subset_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmf_pkg::S_PROD) |-> (r_subset != '0))
        else $error("Empty subset reached the product stage.");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == cmf_pkg::S_PROD || r_state == cmf_pkg::S_DONE))
        else $error("Accepted word did not start a query.");

    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmf_pkg::S_DONE && out_free)
            |=> (o_count.multiple_count <= cmf_pkg::RESULT_W'(r_m)))
        else $error("Result exceeds the upper limit.");

endmodule
